>>> src/ijs_pkg.sv
// shared constants for the interval jitter statistics block
package ijs_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned CNT_W     = $clog2(DATA_W);
  localparam int unsigned WIN_W     = 21;
  localparam int unsigned OUT_W     = 55;
  localparam int unsigned NS_W      = 10;
  localparam int unsigned DIV_W     = WIN_W + NS_W;
  localparam int unsigned REM_W     = DIV_W + 1;
  localparam int unsigned LANES     = 4;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(2000);
  localparam logic [NS_W-1:0]  NS_PER_US    = NS_W'(1000);

  // divider lanes
  localparam int unsigned LANE_MIN  = 0;
  localparam int unsigned LANE_MEAN = 1;
  localparam int unsigned LANE_MAX  = 2;
  localparam int unsigned LANE_ALL  = 3;

  // register indexes
  localparam logic REG_WINDOW_COUNT = 1'b0;

  typedef logic [DATA_W-1:0] word_t;

endpackage

>>> src/interval_jitter_statistics_top.sv
// interval jitter statistics: bit-serial interval update and four-lane serial divider
//
//   channel   signals                                      direction
//   input     in_valid, in_ready, tick_time_ns             into block
//   output    out_valid, out_ready, min/mean/max/all_time  out of block
//   config    psel, penable, pwrite, paddr, pwdata,        apb slave
//             prdata, pready
//
// the first tick after reset only records its timestamp. every later tick runs the
// bit-serial subtract, accumulate and compare over all 64 bits, then an update state and
// the return to idle. a tick that closes a window then runs the shared
// restoring divider (one quotient bit per cycle in all four lanes) and waits
// there while the previous report is still held in the output register.
// reset is synchronous; it clears control and window state and sets the window count to 2000.
module interval_jitter_statistics_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ijs_pkg::DATA_W-1:0]    tick_time_ns,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ijs_pkg::OUT_W-1:0]     min_interval_us,
  output logic [ijs_pkg::OUT_W-1:0]     mean_interval_us,
  output logic [ijs_pkg::OUT_W-1:0]     max_interval_us,
  output logic [ijs_pkg::OUT_W-1:0]     all_time_max_us,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ijs_pkg::ADDR_W-1:0]    paddr,
  input  logic [ijs_pkg::PDATA_W-1:0]   pwdata,
  output logic [ijs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import ijs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SER  = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DATA_W - 1);

  logic [2:0]        state;
  logic [CNT_W-1:0]  bit_cnt;
  logic [WIN_W-1:0]  window_count;
  logic              seen_first_tick;
  logic [WIN_W-1:0]  interval_count;
  word_t             tick_sr;
  word_t             previous_time;
  word_t             window_min;
  word_t             window_max;
  word_t             window_sum;
  word_t             overall_max;
  logic              borrow;
  logic              carry;
  logic              lt_min;
  logic              gt_max;
  logic              gt_all;

  word_t             quo [LANES];
  logic [REM_W-1:0]  rem [LANES];
  logic [DIV_W-1:0]  mean_div;

  logic              diff_bit;
  logic              borrow_next;
  logic              sum_bit;
  logic              carry_next;
  logic [WIN_W-1:0]  count_next;
  logic [WIN_W-1:0]  limit;
  logic              report;
  logic              cfg_write;
  logic              out_free;

  word_t             quo_next [LANES];
  logic [REM_W-1:0]  rem_next [LANES];

  assign in_ready  = (state == S_IDLE);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    if (paddr[2] == REG_WINDOW_COUNT) begin
      prdata = PDATA_W'(window_count);
    end else begin
      prdata = '0;
    end
  end

  // serial subtract of the previous timestamp and accumulate into the sum
  assign diff_bit    = tick_sr[0] ^ previous_time[0] ^ borrow;
  assign borrow_next = (!tick_sr[0] && previous_time[0]) ||
                       (!(tick_sr[0] ^ previous_time[0]) && borrow);
  assign sum_bit     = window_sum[0] ^ diff_bit ^ carry;
  assign carry_next  = (window_sum[0] && diff_bit) || (window_sum[0] && carry) ||
                       (diff_bit && carry);

  assign count_next = interval_count + WIN_W'(1);
  assign limit      = (window_count == '0) ? WIN_W'(1) : window_count;
  assign report     = (count_next >= limit) && (count_next != '0);

  // one restoring step per lane per cycle
  always_comb begin
    logic [REM_W:0]   shifted;
    logic [REM_W:0]   divisor;
    for (int i = 0; i < LANES; i++) begin
      shifted = {rem[i], quo[i][DATA_W-1]};
      if (i == LANE_MEAN) begin
        divisor = (REM_W + 1)'(mean_div);
      end else begin
        divisor = (REM_W + 1)'(NS_PER_US);
      end
      if (shifted >= divisor) begin
        rem_next[i] = REM_W'(shifted - divisor);
        quo_next[i] = {quo[i][DATA_W-2:0], 1'b1};
      end else begin
        rem_next[i] = REM_W'(shifted);
        quo_next[i] = {quo[i][DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      bit_cnt         <= '0;
      window_count    <= WINDOW_RESET;
      seen_first_tick <= 1'b0;
      interval_count  <= '0;
      previous_time   <= '0;
      window_min      <= '1;
      window_max      <= '0;
      window_sum      <= '0;
      overall_max     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == REG_WINDOW_COUNT) begin
        window_count <= pwdata[WIN_W-1:0];
      end
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (!seen_first_tick) begin
              seen_first_tick <= 1'b1;
              previous_time   <= tick_time_ns;
            end else begin
              tick_sr <= tick_time_ns;
              borrow  <= 1'b0;
              carry   <= 1'b0;
              lt_min  <= 1'b0;
              gt_max  <= 1'b0;
              gt_all  <= 1'b0;
              bit_cnt <= '0;
              state   <= S_SER;
            end
          end
        end

        S_SER: begin
          tick_sr       <= {diff_bit, tick_sr[DATA_W-1:1]};
          previous_time <= {tick_sr[0], previous_time[DATA_W-1:1]};
          window_sum    <= {sum_bit, window_sum[DATA_W-1:1]};
          window_min    <= {window_min[0], window_min[DATA_W-1:1]};
          window_max    <= {window_max[0], window_max[DATA_W-1:1]};
          overall_max   <= {overall_max[0], overall_max[DATA_W-1:1]};
          borrow        <= borrow_next;
          carry         <= carry_next;
          // lsb-first compare: the highest differing bit decides
          if (diff_bit != window_min[0]) begin
            lt_min <= !diff_bit;
          end
          if (diff_bit != window_max[0]) begin
            gt_max <= diff_bit;
          end
          if (diff_bit != overall_max[0]) begin
            gt_all <= diff_bit;
          end
          bit_cnt <= bit_cnt + CNT_W'(1);
          if (bit_cnt == LAST_BIT) begin
            state <= S_UPD;
          end
        end

        S_UPD: begin
          // tick_sr now holds the interval
          if (lt_min) begin
            window_min <= tick_sr;
          end
          if (gt_max) begin
            window_max <= tick_sr;
          end
          if (gt_all) begin
            overall_max <= tick_sr;
          end
          interval_count <= count_next;
          state          <= report ? S_LOAD : S_IDLE;
        end

        S_LOAD: begin
          // floor(floor(sum / n) / 1000) == floor(sum / (n * 1000))
          mean_div        <= DIV_W'(interval_count * NS_PER_US);
          quo[LANE_MIN]   <= window_min;
          quo[LANE_MEAN]  <= window_sum;
          quo[LANE_MAX]   <= window_max;
          quo[LANE_ALL]   <= overall_max;
          for (int i = 0; i < LANES; i++) begin
            rem[i] <= '0;
          end
          interval_count <= '0;
          window_min     <= '1;
          window_max     <= '0;
          window_sum     <= '0;
          bit_cnt        <= '0;
          state          <= S_DIV;
        end

        S_DIV: begin
          for (int i = 0; i < LANES; i++) begin
            quo[i] <= quo_next[i];
            rem[i] <= rem_next[i];
          end
          bit_cnt <= bit_cnt + CNT_W'(1);
          if (bit_cnt == LAST_BIT) begin
            state <= S_FIN;
          end
        end

        S_FIN: begin
          if (out_free) begin
            min_interval_us  <= quo[LANE_MIN][OUT_W-1:0];
            mean_interval_us <= quo[LANE_MEAN][OUT_W-1:0];
            max_interval_us  <= quo[LANE_MAX][OUT_W-1:0];
            all_time_max_us  <= quo[LANE_ALL][OUT_W-1:0];
            state            <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> verif/tb_interval_jitter_statistics_top.sv
// self-checking testbench for the interval jitter statistics block
module tb_interval_jitter_statistics_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ijs_pkg::*;

  localparam int unsigned SPARE_REG     = 1;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned RANDOM_TICKS  = 950;
  localparam int unsigned HOLD_CYCLES   = 800;
  localparam int unsigned MAX_PRINTED   = 100;

  typedef struct {
    logic [OUT_W-1:0] min_us, mean_us, max_us, all_us;
  } jitter_report_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  word_t               tick_time_ns = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OUT_W-1:0]    min_interval_us, mean_interval_us, max_interval_us, all_time_max_us;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // predictor state
  logic [WIN_W-1:0]    win_len = WINDOW_RESET;
  logic [WIN_W-1:0]    gap_count = '0;
  bit                  have_stamp = 1'b0;
  word_t               prev_stamp = '0;
  word_t               win_min = '1;
  word_t               win_max = '0;
  word_t               win_sum = '0;
  word_t               peak_interval = '0;
  jitter_report_t      expected_reports[$];

  int                  errors = 0;
  int unsigned         idle_run = 0;
  word_t               last_stamp = '0;
  bit                  tx_idle_on = 1'b1;
  bit                  rx_idle_on = 1'b1;
  int unsigned         hold_req = 0;

  interval_jitter_statistics_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .tick_time_ns     (tick_time_ns),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .min_interval_us  (min_interval_us),
    .mean_interval_us (mean_interval_us),
    .max_interval_us  (max_interval_us),
    .all_time_max_us  (all_time_max_us),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] got, want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic predict_tick(input word_t stamp);
    word_t            interval_ns;
    logic [WIN_W-1:0] limit;
    jitter_report_t   rep;
    // first tick after reset only anchors the timeline
    if (!have_stamp) begin
      have_stamp = 1'b1;
      prev_stamp = stamp;
      return;
    end
    interval_ns = stamp - prev_stamp;
    prev_stamp  = stamp;
    win_sum += interval_ns;
    if (interval_ns < win_min) win_min = interval_ns;
    if (interval_ns > win_max) win_max = interval_ns;
    if (interval_ns > peak_interval) peak_interval = interval_ns;
    gap_count += 1'b1;
    limit = (win_len == '0) ? WIN_W'(1) : win_len;
    if (gap_count < limit || gap_count == '0) return;
    // mean divides by the intervals actually held, not the window setting
    rep.min_us  = OUT_W'(win_min / NS_PER_US);
    rep.mean_us = OUT_W'((win_sum / word_t'(gap_count)) / NS_PER_US);
    rep.max_us  = OUT_W'(win_max / NS_PER_US);
    rep.all_us  = OUT_W'(peak_interval / NS_PER_US);
    expected_reports.push_back(rep);
    gap_count = '0;
    win_min   = '1;
    win_max   = '0;
    win_sum   = '0;
  endtask

  always @(posedge clk) begin : scoreboard
    jitter_report_t want;
    if (!rst) begin
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_WINDOW_COUNT)
        win_len = pwdata[WIN_W-1:0];
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("unexpected report, min %0d mean %0d max %0d all %0d",
                                    min_interval_us, mean_interval_us, max_interval_us,
                                    all_time_max_us));
        end else begin
          want = expected_reports.pop_front();
          check_field("min_interval_us", min_interval_us, want.min_us);
          check_field("mean_interval_us", mean_interval_us, want.mean_us);
          check_field("max_interval_us", max_interval_us, want.max_us);
          check_field("all_time_max_us", all_time_max_us, want.all_us);
        end
      end
      if (in_valid && in_ready) predict_tick(tick_time_ns);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
        idle_run = 0;
      else
        idle_run++;
    end
  end

  initial begin : watchdog
    while (idle_run < STALL_LIMIT) @(negedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned idle_len(input bit enabled);
    int unsigned pick;
    if (!enabled) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // result side: random stalls, plus a long hold-off when a test asks for one
  initial begin : report_sink
    int unsigned n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = idle_len(rx_idle_on);
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_tick(input word_t stamp);
    int unsigned gap;
    gap = idle_len(tx_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    tick_time_ns <= stamp;
    last_stamp = stamp;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input int unsigned index, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(index * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // let every report drain, then give a tick with no report time to finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_first_tick();
    send_tick(64'd0);
    send_tick(64'd1500);
    send_tick(64'd4000);
    send_tick(64'd4000);
    send_tick(64'd5999);
  endtask

  task automatic test_window_lowered();
    settle();
    // count already past the new window, so the next interval reports
    write_reg(REG_WINDOW_COUNT, 32'd3);
    send_tick(64'd7000);
    send_tick(64'd8000);
    send_tick(64'd9000);
    send_tick(64'd10500);
  endtask

  task automatic test_window_extremes();
    settle();
    write_reg(REG_WINDOW_COUNT, 32'd2000000);
    send_tick(last_stamp + 64'd1200);
    send_tick(last_stamp + 64'd800);
    settle();
    write_reg(REG_WINDOW_COUNT, '1);
    send_tick(last_stamp + 64'd3000);
    send_tick(last_stamp + 64'd999);
    settle();
    write_reg(SPARE_REG, 32'd1);
    send_tick(last_stamp + 64'd1001);
    settle();
    // zero window acts as one
    write_reg(REG_WINDOW_COUNT, 32'd0);
    send_tick(last_stamp + 64'd2500);
    send_tick(last_stamp + 64'd1);
    send_tick(last_stamp + 64'd999999);
    settle();
    write_reg(REG_WINDOW_COUNT, 32'hFFE0_0002);
    send_tick(last_stamp + 64'd4321);
    send_tick(last_stamp + 64'd1234);
  endtask

  task automatic test_wrap_extremes();
    settle();
    write_reg(REG_WINDOW_COUNT, 32'd1);
    send_tick(last_stamp);
    send_tick('1);
    send_tick('0);
    send_tick(64'h8000_0000_0000_0000);
    send_tick(64'h7FFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_output_hold_fills_block();
    settle();
    write_reg(REG_WINDOW_COUNT, 32'd1);
    tx_idle_on = 1'b0;
    hold_req = HOLD_CYCLES;
    repeat (30) send_tick(last_stamp + 64'd1000 + word_t'($urandom_range(0, 500)));
    tx_idle_on = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    settle();
    write_reg(REG_WINDOW_COUNT, 32'd2);
    repeat (15) send_tick(last_stamp + 64'd5000 + word_t'($urandom_range(0, 3000)));
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (15) send_tick(last_stamp + 64'd5000 + word_t'($urandom_range(0, 3000)));
  endtask

  // noisy adds raw timestamps, backward steps and repeats to the periodic stream
  task automatic run_random_windows(input int unsigned total, input bit noisy);
    int unsigned        sent;
    int unsigned        phase;
    int unsigned        shift;
    int unsigned        pick;
    word_t              period;
    word_t              stamp;
    logic [WIN_W-1:0]   win;
    logic [PDATA_W-1:0] data;
    sent  = 0;
    phase = 0;
    while (sent < total) begin
      settle();
      pick = $urandom_range(0, 99);
      if (pick < 10) win = '0;
      else if (pick < 30) win = WIN_W'($urandom_range(1, 2));
      else if (pick < 85) win = WIN_W'($urandom_range(3, 12));
      else win = WIN_W'($urandom_range(13, 64));
      data = $urandom;
      data[WIN_W-1:0] = win;
      write_reg(REG_WINDOW_COUNT, data);
      // clean stream grows the period so the all-time maximum keeps moving
      shift  = noisy ? $urandom_range(0, 40) : (phase < 40 ? phase : 40);
      period = word_t'($urandom_range(400, 4000)) << shift;
      tx_idle_on = ($urandom_range(0, 4) != 0);
      rx_idle_on = ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(8, 40)) begin
        pick = $urandom_range(0, 99);
        if (!noisy || pick < 80)
          stamp = last_stamp + period + (word_t'($urandom_range(0, 255)) << shift)
                  - (word_t'($urandom_range(0, 255)) << shift);
        else if (pick < 88)
          stamp = {$urandom, $urandom};
        else if (pick < 95)
          stamp = last_stamp - word_t'($urandom_range(1, 1 << 20));
        else
          stamp = last_stamp;
        send_tick(stamp);
        sent++;
      end
      phase++;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_first_tick();
    test_window_lowered();
    test_window_extremes();
    run_random_windows(RANDOM_TICKS, 1'b0);
    test_output_hold_fills_block();
    test_pause_until_drained();
    test_wrap_extremes();
    run_random_windows(RANDOM_TICKS, 1'b1);
    settle();
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
